// ----- rtl/pip_pkg.sv -----
// ---------------------------------------------------------------------------
// pip_pkg
// Shared widths, constants and types of the point-in-polygon crossing test.
// ---------------------------------------------------------------------------
package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_W      = 16;
    localparam int LEFT_W       = COORD_W + 2;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int LDIFF_W      = LEFT_W + 1;
    localparam int PROD_W       = DIFF_W + LDIFF_W + 2;
    localparam int CNT_W        = 7;
    localparam int S_DATA_W     = 80;
    localparam int M_DATA_W     = 8;

    localparam int CROSS_CAP_I  = (MAX_VERTICES < 127) ? MAX_VERTICES : 127;
    localparam logic [CNT_W-1:0] CROSS_CAP = CNT_W'(CROSS_CAP_I);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [LEFT_W-1:0]  left_t;

    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
    } pip_seg_t;

    typedef struct packed {
        coord_t qx;
        coord_t qy;
        left_t  lx;
        logic   ray_nz;
    } pip_query_t;

    typedef struct packed {
        logic first;
        logic last;
        logic cross_a;
        logic cross_b;
    } pip_step_t;

endpackage

// ----- rtl/point_in_polygon_ray_crossing.sv -----
// ---------------------------------------------------------------------------
// point_in_polygon_ray_crossing
// Crossing-number point-in-polygon test over a stream of polygon vertices.
// ---------------------------------------------------------------------------
// One vertex beat is taken every cycle. The beat marked in s_tuser starts a
// polygon and latches the query point and ray; each later beat tests the edge
// from the previous vertex, and the beat marked by s_tlast also tests the
// closing edge and yields one result beat via the segment, product, crossing
// and result registers. Intake pauses only while a finished result waits on
// the master side and the next polygon's last vertex has reached the counter stage.
module point_in_polygon_ray_crossing (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // point_x, point_y, ray_length, vertex_x, vertex_y
    input  logic [pip_pkg::S_DATA_W-1:0]  s_tdata,
    // first_vertex
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // inside_res, crossings
    output logic [pip_pkg::M_DATA_W-1:0]  m_tdata
);
    import pip_pkg::*;

    logic       en;
    logic       s_accept;
    coord_t     in_px;
    coord_t     in_py;
    coord_t     in_vx;
    coord_t     in_vy;
    logic [COORD_W-1:0] in_ray;

    coord_t     first_vx_reg;
    coord_t     first_vy_reg;
    coord_t     prev_vx_reg;
    coord_t     prev_vy_reg;
    pip_query_t query_reg;
    pip_query_t query_next;
    coord_t     close_x;
    coord_t     close_y;

    logic       v1_reg;
    logic       v2_reg;
    logic       v3_reg;
    pip_seg_t   seg_a_reg;
    pip_seg_t   seg_b_reg;
    pip_query_t q1_reg;
    logic [1:0] flags1_reg;
    logic [1:0] flags2_reg;
    logic [1:0] flags3_reg;
    logic       cross_a;
    logic       cross_b;
    pip_step_t  step;
    logic       inside_res;
    logic [CNT_W-1:0] crossings;

    assign in_px  = s_tdata[15:0];
    assign in_py  = s_tdata[31:16];
    assign in_ray = s_tdata[47:32];
    assign in_vx  = s_tdata[63:48];
    assign in_vy  = s_tdata[79:64];

    assign en       = !(m_tvalid && !m_tready && v3_reg && flags3_reg[0]);
    assign s_tready = en;
    assign s_accept = s_tvalid && en;

    always_comb begin
        if (s_tuser) begin
            query_next.qx     = in_px;
            query_next.qy     = in_py;
            query_next.lx     = LEFT_W'(in_px) - $signed({2'b00, in_ray});
            query_next.ray_nz = (in_ray != '0);
            close_x           = in_vx;
            close_y           = in_vy;
        end else begin
            query_next = query_reg;
            close_x    = first_vx_reg;
            close_y    = first_vy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_vx_reg <= '0;
            first_vy_reg <= '0;
            prev_vx_reg  <= '0;
            prev_vy_reg  <= '0;
            query_reg    <= '0;
        end else if (s_accept) begin
            first_vx_reg <= close_x;
            first_vy_reg <= close_y;
            prev_vx_reg  <= in_vx;
            prev_vy_reg  <= in_vy;
            query_reg    <= query_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            seg_a_reg  <= '{ax: prev_vx_reg, ay: prev_vy_reg, bx: in_vx, by: in_vy};
            seg_b_reg  <= '{ax: in_vx, ay: in_vy, bx: close_x, by: close_y};
            q1_reg     <= query_next;
            flags1_reg <= {s_tuser, s_tlast};
            flags2_reg <= flags1_reg;
            flags3_reg <= flags2_reg;
        end
    end

    pip_edge_test u_edge_a (
        .aclk    (aclk),
        .en      (en),
        .seg_i   (seg_a_reg),
        .query_i (q1_reg),
        .cross_o (cross_a)
    );

    pip_edge_test u_edge_b (
        .aclk    (aclk),
        .en      (en),
        .seg_i   (seg_b_reg),
        .query_i (q1_reg),
        .cross_o (cross_b)
    );

    // drop the open edge on a first vertex, the closing edge unless last
    assign step.first   = flags3_reg[1];
    assign step.last    = flags3_reg[0];
    assign step.cross_a = cross_a && !flags3_reg[1];
    assign step.cross_b = cross_b && flags3_reg[0];

    pip_tally u_tally (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_valid  (v3_reg && en),
        .step_i      (step),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .inside_o    (inside_res),
        .crossings_o (crossings)
    );

    assign m_tdata = {crossings, inside_res};

    a_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:1] <= CROSS_CAP))
        else $error("crossing count above cap");

    a_zero_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[7:1] == '0) |-> !m_tdata[0])
        else $error("zero crossings reported inside");

    a_parity: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[7:1] < CROSS_CAP) |-> (m_tdata[0] == m_tdata[1]))
        else $error("parity disagrees with unsaturated count");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");

endmodule

// ----- rtl/pip_edge_test.sv -----
// ---------------------------------------------------------------------------
// pip_edge_test
// Two-stage crossing test of one polygon edge against the horizontal segment.
// ---------------------------------------------------------------------------
module pip_edge_test (
    input  logic                aclk,
    input  logic                en,
    input  pip_pkg::pip_seg_t   seg_i,
    input  pip_pkg::pip_query_t query_i,
    output logic                cross_o
);
    import pip_pkg::*;

    logic signed [DIFF_W-1:0]         dy;
    logic signed [DIFF_W-1:0]         dx;
    logic signed [LDIFF_W-1:0]        lbx;
    logic signed [DIFF_W-1:0]         qbx;
    logic signed [DIFF_W-1:0]         qby;
    logic signed [DIFF_W-1:0]         qay;
    logic signed [DIFF_W+LDIFF_W-1:0] p_left;
    logic signed [2*DIFF_W-1:0]       p_query;
    logic signed [2*DIFF_W-1:0]       p_side;
    logic                             horiz_cross;

    logic signed [DIFF_W+LDIFF_W-1:0] p_left_reg;
    logic signed [2*DIFF_W-1:0]       p_query_reg;
    logic signed [2*DIFF_W-1:0]       p_side_reg;
    logic                             horiz_cross_reg;
    logic                             cross_reg;

    logic signed [PROD_W-1:0]         o_left;
    logic signed [PROD_W-1:0]         o_query;
    logic                             cross_next;

    assign dy  = DIFF_W'($signed(seg_i.by)) - DIFF_W'($signed(seg_i.ay));
    assign dx  = DIFF_W'($signed(seg_i.bx)) - DIFF_W'($signed(seg_i.ax));
    assign lbx = LDIFF_W'($signed(query_i.lx)) - LDIFF_W'($signed(seg_i.bx));
    assign qbx = DIFF_W'($signed(query_i.qx)) - DIFF_W'($signed(seg_i.bx));
    assign qby = DIFF_W'($signed(query_i.qy)) - DIFF_W'($signed(seg_i.by));
    assign qay = DIFF_W'($signed(query_i.qy)) - DIFF_W'($signed(seg_i.ay));

    assign p_left  = dy * lbx;
    assign p_query = dy * qbx;
    assign p_side  = dx * qby;

    // endpoints on different sides of the segment's line, ray of non-zero length
    assign horiz_cross = query_i.ray_nz &&
        ({qay > 0, qay == 0} != {qby > 0, qby == 0});

    always_ff @(posedge aclk) begin
        if (en) begin
            p_left_reg      <= p_left;
            p_query_reg     <= p_query;
            p_side_reg      <= p_side;
            horiz_cross_reg <= horiz_cross;
        end
    end

    assign o_left  = PROD_W'(p_left_reg) - PROD_W'(p_side_reg);
    assign o_query = PROD_W'(p_query_reg) - PROD_W'(p_side_reg);
    assign cross_next = horiz_cross_reg &&
        ({o_left < 0, o_left == 0} != {o_query < 0, o_query == 0});

    always_ff @(posedge aclk) begin
        if (en) begin
            cross_reg <= cross_next;
        end
    end

    assign cross_o = cross_reg;

endmodule

// ----- rtl/pip_tally.sv -----
// ---------------------------------------------------------------------------
// pip_tally
// Crossing counter with parity and the result register of the master side.
// ---------------------------------------------------------------------------
module pip_tally (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step_valid,
    input  pip_pkg::pip_step_t          step_i,
    input  logic                        m_tready,
    output logic                        m_tvalid,
    output logic                        inside_o,
    output logic [pip_pkg::CNT_W-1:0]   crossings_o
);
    import pip_pkg::*;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             par_reg;
    logic             par_next;
    logic             valid_reg;
    logic             inside_reg;
    logic [CNT_W-1:0] crossings_reg;
    logic [CNT_W-1:0] base;
    logic [CNT_W:0]   sum;

    always_comb begin
        base = step_i.first ? '0 : cnt_reg;
        sum  = (CNT_W+1)'(base) + (CNT_W+1)'(step_i.cross_a) + (CNT_W+1)'(step_i.cross_b);
        if (sum > (CNT_W+1)'(CROSS_CAP)) begin
            cnt_next = CROSS_CAP;
        end else begin
            cnt_next = sum[CNT_W-1:0];
        end
        par_next = (step_i.first ? 1'b0 : par_reg) ^ step_i.cross_a ^ step_i.cross_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            par_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (step_valid) begin
                cnt_reg <= step_i.last ? '0 : cnt_next;
                par_reg <= step_i.last ? 1'b0 : par_next;
            end
            if (step_valid && step_i.last) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step_valid && step_i.last) begin
            inside_reg    <= par_next;
            crossings_reg <= cnt_next;
        end
    end

    assign m_tvalid    = valid_reg;
    assign inside_o    = inside_reg;
    assign crossings_o = crossings_reg;

endmodule

// ----- tb/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the crossing-number point-in-polygon test.
// A fixed table of vertex beats covers the corner cases first. Random polygons,
// broken polygons, raw noise and long zigzag outlines, some of which saturate
// the counter, follow. Both stream sides pause at random. Every result beat is
// compared field by field with the table's value or a local crossing model.
// ---------------------------------------------------------------------------
module tb_top;
    import pip_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BEATS = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int ROW_COUNT    = 25;

    typedef enum logic [1:0] {TURN_NONE, TURN_LEFT, TURN_RIGHT} turn_e;

    typedef struct packed {
        logic             inside_res;
        logic [CNT_W-1:0] crossings;
    } verdict_t;

    typedef struct {
        coord_t      px;
        coord_t      py;
        logic [15:0] ray;
        coord_t      vx;
        coord_t      vy;
        logic        first;
        logic        last;
        logic        typed;
        verdict_t    want;
    } vertex_beat_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    int       cycles       = 0;
    int       mismatches   = 0;
    int       beats_sent   = 0;
    int       results_seen = 0;
    int       saturated    = 0;
    int       hold_cycles  = 0;
    bit       steady       = 1'b0;
    verdict_t verdicts_due[$];

    // crossing model state
    longint anchor_x = 0, anchor_y = 0, trail_x = 0, trail_y = 0;
    longint probe_x = 0, probe_y = 0, reach_x = 0;
    int     tally = 0;
    bit     odd   = 1'b0;

    point_in_polygon_ray_crossing dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic turn_e turn_of(input longint ax, ay, bx, by, cx, cy);
        longint area;
        area = (by - ay) * (cx - bx) - (bx - ax) * (cy - by);
        if (area == 0)
            return TURN_NONE;
        return (area > 0) ? TURN_LEFT : TURN_RIGHT;
    endfunction

    function automatic void tally_edge(input longint ax, ay, bx, by);
        if (turn_of(ax, ay, bx, by, reach_x, probe_y) != turn_of(ax, ay, bx, by, probe_x, probe_y)
            && turn_of(reach_x, probe_y, probe_x, probe_y, ax, ay)
               != turn_of(reach_x, probe_y, probe_x, probe_y, bx, by)) begin
            odd = !odd;
            if (tally < int'(CROSS_CAP))
                tally++;
        end
    endfunction

    function automatic bit crossing_step(input vertex_beat_t b, output verdict_t v);
        longint vx, vy;
        vx = b.vx;
        vy = b.vy;
        v  = '0;
        if (b.first) begin
            probe_x  = b.px;
            probe_y  = b.py;
            reach_x  = probe_x - longint'(b.ray);
            anchor_x = vx;
            anchor_y = vy;
            tally    = 0;
            odd      = 1'b0;
        end else begin
            tally_edge(trail_x, trail_y, vx, vy);
        end
        trail_x = vx;
        trail_y = vy;
        if (!b.last)
            return 1'b0;
        tally_edge(vx, vy, anchor_x, anchor_y);
        v.inside_res = odd;
        v.crossings  = CNT_W'(tally);
        tally        = 0;
        odd          = 1'b0;
        return 1'b1;
    endfunction

    function automatic coord_t rand_coord(input int scale);
        return coord_t'(int'($urandom_range(0, 2 * scale)) - scale);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
        mismatches++;
    endtask

    task automatic push_vertex(input vertex_beat_t b);
        verdict_t v;
        int       gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b.vy, b.vx, b.ray, b.py, b.px};
        s_tuser  <= b.first;
        s_tlast  <= b.last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        beats_sent++;
        if (crossing_step(b, v))
            verdicts_due.push_back(b.typed ? b.want : v);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdicts_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic send_polygon(input int n, input int scale, input bit broken);
        vertex_beat_t b;
        bit           drop_last;
        int           cut;
        b           = '{default: 0};
        b.px        = rand_coord(scale);
        b.py        = rand_coord(scale);
        b.ray       = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                  : 16'($urandom_range(0, 2 * scale));
        drop_last   = $urandom_range(0, 1);
        cut         = $urandom_range(1, n - 1);
        for (int i = 0; i < n; i++) begin
            b.vx    = rand_coord(scale);
            b.vy    = ($urandom_range(0, 7) == 0) ? b.py : rand_coord(scale);
            b.first = (i == 0) || (broken && !drop_last && i == cut);
            b.last  = (i == n - 1) && !(broken && drop_last);
            push_vertex(b);
        end
    endtask

    always @(posedge aclk) begin
        verdict_t want;
        if (!aresetn) begin
            m_tready    <= 1'b0;
            hold_cycles = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (verdicts_due.size() == 0) begin
                    report_mismatch("unexpected result beat", int'(m_tdata), 0);
                end else begin
                    want = verdicts_due.pop_front();
                    if (m_tdata[0] !== want.inside_res)
                        report_mismatch("inside_res", int'(m_tdata[0]),
                                        int'(want.inside_res));
                    if (m_tdata[CNT_W:1] !== want.crossings)
                        report_mismatch("crossings", int'(m_tdata[CNT_W:1]),
                                        int'(want.crossings));
                    results_seen++;
                    if (want.crossings == CROSS_CAP)
                        saturated++;
                end
                hold_cycles = steady ? 0 : $urandom_range(0, 5);
            end
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    vertex_beat_t directed_rows [ROW_COUNT] = '{
        // no first beat after reset: zero query, degenerate segment
        '{1, 2, 7, 5, 5, 0, 1, 1, '{0, 0}},
        // one-vertex polygon
        '{0, 0, 100, -50, 0, 1, 1, 1, '{0, 0}},
        // square around the point, crossed once on its left side
        '{0, 0, 100, -10, -10, 1, 0, 0, '{0, 0}},
        '{0, 0, 100, 10, -10, 0, 0, 0, '{0, 0}},
        '{0, 0, 100, 10, 10, 0, 0, 0, '{0, 0}},
        '{0, 0, 100, -10, 10, 0, 1, 1, '{1, 1}},
        // carry on from the closed square without a first beat
        '{0, 0, 0, -20, 5, 0, 0, 0, '{0, 0}},
        '{0, 0, 0, -20, -5, 0, 1, 0, '{0, 0}},
        // zero ray length
        '{0, 0, 0, -10, -10, 1, 0, 0, '{0, 0}},
        '{0, 0, 0, 10, -10, 0, 0, 0, '{0, 0}},
        '{0, 0, 0, 0, 10, 0, 1, 0, '{0, 0}},
        // coordinate extremes
        '{32767, -32768, 65535, -32768, 32767, 1, 0, 0, '{0, 0}},
        '{32767, -32768, 65535, 32767, 32767, 0, 0, 0, '{0, 0}},
        '{32767, -32768, 65535, -32768, -32768, 0, 1, 0, '{0, 0}},
        '{-32768, 0, 65535, -32768, -1, 1, 0, 0, '{0, 0}},
        '{-32768, 0, 65535, 32767, -32768, 0, 0, 0, '{0, 0}},
        '{-32768, 0, 65535, 32767, 32767, 0, 0, 0, '{0, 0}},
        '{-32768, 0, 65535, -32768, 1, 0, 1, 0, '{0, 0}},
        // abandoned polygon, restarted by the next first beat
        '{5, 5, 20, 0, 0, 1, 0, 0, '{0, 0}},
        // vertex lying on the segment
        '{0, 0, 50, -20, 0, 1, 0, 0, '{0, 0}},
        '{0, 0, 50, 10, -10, 0, 0, 0, '{0, 0}},
        '{0, 0, 50, 10, 10, 0, 1, 0, '{0, 0}},
        // edge along the segment
        '{0, 0, 50, -30, 0, 1, 0, 0, '{0, 0}},
        '{0, 0, 50, -5, 0, 0, 0, 0, '{0, 0}},
        '{0, 0, 50, -5, 10, 0, 1, 0, '{0, 0}}
    };

    initial begin
        vertex_beat_t b;
        int           n;
        int           shift;
        int           kind;
        int           scale;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            push_vertex(directed_rows[i]);
        wait_for_results();

        while (beats_sent < ROW_COUNT + RANDOM_BEATS) begin
            steady = ($urandom_range(0, 3) == 0);
            kind   = $urandom_range(0, 99);
            case ($urandom_range(0, 3))
                0: scale = 16;
                1: scale = 256;
                2: scale = 4096;
                default: scale = 32767;
            endcase
            if (kind < 55) begin
                send_polygon($urandom_range(3, 12), scale, 1'b0);
            end else if (kind < 70) begin
                send_polygon($urandom_range(3, 12), scale, 1'b1);
            end else if (kind < 85) begin
                // raw noise over every bit
                b = '{default: 0};
                repeat ($urandom_range(1, 6)) begin
                    b.px    = coord_t'($urandom_range(0, 65535));
                    b.py    = coord_t'($urandom_range(0, 65535));
                    b.ray   = 16'($urandom_range(0, 65535));
                    b.vx    = coord_t'($urandom_range(0, 65535));
                    b.vy    = coord_t'($urandom_range(0, 65535));
                    b.first = ($urandom_range(0, 3) == 0);
                    b.last  = ($urandom_range(0, 3) == 0);
                    push_vertex(b);
                end
            end else if (kind < 90) begin
                // zigzag outline crossing the segment on every edge but, for odd n, the closing one
                n     = $urandom_range(62, 70);
                shift = $urandom_range(0, 500);
                b     = '{default: 0};
                b.ray = 16'd1000;
                for (int i = 0; i < n; i++) begin
                    b.vx    = coord_t'(-(2 * i + 1) - shift);
                    b.vy    = (i % 2 == 0) ? coord_t'(10) : coord_t'(-10);
                    b.first = (i == 0);
                    b.last  = (i == n - 1);
                    push_vertex(b);
                end
            end else begin
                send_polygon($urandom_range(13, 40), scale, 1'b0);
            end
            if ($urandom_range(0, 49) == 0)
                wait_for_results();
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d vertex beats and %0d polygon results", beats_sent, results_seen);
        $display("%0d results hit the crossing cap", saturated);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
